// ===== hw/rtl/afr_pkg.sv =====
// Shared types and constants for the addressed frame receiver.
package afr_pkg;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [1:0] ACK_LIMIT   = 2'd2;
  localparam logic [5:0] BED_CALL_M  = 6'h02;
  localparam logic [6:0] STAT_HI_M   = 7'h6e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_ninth;
    logic [5:0] status_low;
    logic [6:0] status_high;
  } in_item_t;

  typedef struct packed {
    logic [6:0] tx_byte;
    logic       tx_ninth;
    logic       last;
    logic       smoke_power;
    logic       bed_call_clear;
  } out_item_t;

  // Both response bytes of one matched frame.
  typedef struct packed {
    logic [5:0] stat_lo;
    logic [6:0] stat_hi;
    logic       smoke_power;
    logic       bed_call_clear;
  } resp_pair_t;

  // Handshake between frame decoder and response serialiser.
  typedef struct packed {
    logic load;
  } pair_req_t;

  typedef struct packed {
    logic ready;
  } pair_rsp_t;

endpackage

// ===== hw/rtl/afr_frame.sv =====
// Input register, frame state and match decode.
module afr_frame (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [5:0]             cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  afr_pkg::in_item_t      in_data_i,
  output afr_pkg::pair_req_t     req_o,
  output afr_pkg::resp_pair_t    pair_o,
  input  afr_pkg::pair_rsp_t     rsp_i
);

  logic [5:0]        node_addr_q;
  logic              item_valid_q;
  afr_pkg::in_item_t item_q;

  logic [1:0] phase_q, phase_d;
  logic [7:0] first_q, first_d;
  logic [6:0] second_q, second_d;
  logic       parity_q, parity_d;
  logic [1:0] ack_q, ack_d;

  logic good, start, emit, clr, advance, in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q <= '0;
    end else if (cfg_we_i) begin
      node_addr_q <= cfg_data_i;
    end
  end

  // item advances when it emits nothing or the serialiser can take the pair
  assign advance    = item_valid_q && (!emit || rsp_i.ready);
  assign in_stall_o = item_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_take) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
  end

  assign good  = (item_q.rx_ninth == ^item_q.rx_byte);
  assign start = item_q.rx_byte[7];

  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    parity_d = parity_q;
    ack_d    = ack_q;
    emit     = 1'b0;
    clr      = 1'b0;
    unique case (phase_q)
      afr_pkg::PH_IDLE: begin
        if (start) begin
          first_d  = item_q.rx_byte;
          parity_d = good;
          phase_d  = afr_pkg::PH_SECOND;
        end
      end
      afr_pkg::PH_SECOND: begin
        if (start) begin
          phase_d = afr_pkg::PH_IDLE;
        end else begin
          second_d = item_q.rx_byte[6:0];
          parity_d = parity_q & good;
          phase_d  = afr_pkg::PH_THIRD;
        end
      end
      afr_pkg::PH_THIRD: begin
        phase_d = afr_pkg::PH_IDLE;
        emit    = !start && parity_q && good && (first_q[5:0] == node_addr_q);
      end
      default: begin
        phase_d = afr_pkg::PH_IDLE;
      end
    endcase
    if (emit && second_q[1]) begin
      if (ack_q == afr_pkg::ACK_LIMIT) begin
        clr   = 1'b1;
        ack_d = '0;
      end else begin
        ack_d = ack_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= afr_pkg::PH_IDLE;
      first_q  <= '0;
      second_q <= '0;
      parity_q <= 1'b1;
      ack_q    <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
      parity_q <= parity_d;
      ack_q    <= ack_d;
    end
  end

  assign req_o.load            = advance && emit;
  assign pair_o.stat_lo        = clr ? (item_q.status_low & ~afr_pkg::BED_CALL_M)
                                     : item_q.status_low;
  assign pair_o.stat_hi        = item_q.status_high & afr_pkg::STAT_HI_M;
  assign pair_o.smoke_power    = ~first_q[6];
  assign pair_o.bed_call_clear = clr;

  a_phase_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == afr_pkg::PH_IDLE || phase_q == afr_pkg::PH_SECOND ||
    phase_q == afr_pkg::PH_THIRD)
    else $error("frame phase left its legal codes");

  a_ack_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack_q != 2'd3)
    else $error("ack counter reached three");

  a_load_ends_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.load |=> phase_q == afr_pkg::PH_IDLE)
    else $error("frame not closed after response load");

endmodule

// ===== hw/rtl/afr_resp.sv =====
// Response pair register and two-byte serialiser.
module afr_resp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  afr_pkg::pair_req_t   req_i,
  input  afr_pkg::resp_pair_t  pair_i,
  output afr_pkg::pair_rsp_t   rsp_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output afr_pkg::out_item_t   out_data_o
);

  logic                pair_valid_q;
  logic                beat_q;
  afr_pkg::resp_pair_t pair_q;
  logic                free;

  assign free        = pair_valid_q && beat_q && !out_stall_i;
  assign rsp_o.ready = !pair_valid_q || free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_valid_q <= 1'b0;
      beat_q       <= 1'b0;
    end else if (req_i.load) begin
      pair_valid_q <= 1'b1;
      beat_q       <= 1'b0;
    end else if (pair_valid_q && !out_stall_i) begin
      pair_valid_q <= !beat_q;
      beat_q       <= !beat_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      pair_q <= pair_i;
    end
  end

  assign out_valid_o               = pair_valid_q;
  assign out_data_o.tx_byte        = beat_q ? pair_q.stat_hi : {1'b0, pair_q.stat_lo};
  assign out_data_o.tx_ninth       = ~^out_data_o.tx_byte;
  assign out_data_o.last           = beat_q;
  assign out_data_o.smoke_power    = pair_q.smoke_power;
  assign out_data_o.bed_call_clear = pair_q.bed_call_clear;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.load |-> !pair_valid_q || free)
    else $error("response pair overwritten before delivery");

  a_first_then_second : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_valid_q && !beat_q && !out_stall_i |=> pair_valid_q && beat_q)
    else $error("second response byte missing");

  a_beat_needs_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q |-> pair_valid_q)
    else $error("beat marker set without a pair");

endmodule

// ===== hw/rtl/addressed_frame_receiver_top.sv =====
// Top level of the addressed frame receiver.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | in        | in_valid_i/in_stall_o   | in_data_i  (in_item_t)
//  out     | out       | out_valid_o/out_stall_i | out_data_o (out_item_t)
//  cfg     | in        | cfg_we_i                | cfg_data_i (node address)
//
// A character is registered on transfer and decoded against the frame state
// in the following cycle; the state updates as the character leaves.
// Characters are taken back to back while the input does not stall. A matched
// third byte loads both response bytes at once, and the first is offered in
// the cycle after the decode. The two output transfers fit inside the next
// frame's three characters, so the single pair register only holds the input
// back when the output stalls.
// Reset clears the frame phase, ack counter, node address and all valids.
// A stalled output holds its byte; the input stalls only while a matched
// frame waits for the pair register to drain.
module addressed_frame_receiver_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  afr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output afr_pkg::out_item_t out_data_o
);

  afr_pkg::pair_req_t  req;   // pair load request
  afr_pkg::pair_rsp_t  rsp;   // serialiser can take a pair
  afr_pkg::resp_pair_t pair;  // both response bytes

  // frame assembly, parity/address check, ack counting
  afr_frame u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .req_o      (req),
    .pair_o     (pair),
    .rsp_i      (rsp)
  );

  // two-byte response output with complemented parity
  afr_resp u_resp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .pair_i      (pair),
    .rsp_o       (rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
